// ----- sv/cbq_pkg.sv -----
`timescale 1ns / 1ps

package cbq_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_SECTIONS_DEF = 12;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COEF_WIDTH_DEF   = 24;

    // Fixed number formats
    localparam int STATE_W    = 32;
    localparam int STATE_FRAC = 28;
    localparam int ACC_W      = 64;
    localparam int TABLE_FRAC = 22;
    localparam int TABLE_ROWS = 12;
    localparam int TAPS       = 5;

    // Section count register
    localparam int                 CFG_W          = 4;
    localparam logic [CFG_W-1:0]   SECTIONS_RESET = CFG_W'(12);

    // Coefficient order within a section: b0, b1, b2, a1, a2
    typedef enum logic [2:0] {
        TAP_B0,
        TAP_B1,
        TAP_B2,
        TAP_A1,
        TAP_A2
    } tap_t;

    // Band-pass cascade, Q2.22, rows of b0, b1, b2, a1, a2
    localparam int COEF_TABLE [TABLE_ROWS][TAPS] = '{
        '{ 3447318, -6823985, 3447318, -6925458, 4010759},
        '{ 3447318, -5564758, 3447318, -8225298, 4138619},
        '{ 3274762, -6488293, 3274762, -6561056, 3627910},
        '{ 3274762, -5176997, 3274762, -8114271, 4022347},
        '{ 2997612, -5949814, 2997612, -6094085, 3163440},
        '{ 2997612, -4480489, 2997612, -7987250, 3886972},
        '{ 2564407, -5102866, 2564407, -7823974, 3714144},
        '{ 2564407, -3301525, 2564407, -5500610, 2560997},
        '{ 1935627, -3862435, 1935627, -7594106, 3478064},
        '{ 1935627, -1353079, 1935627, -4874567, 1851196},
        '{ 1258162, -2515595, 1258162, -7263760, 3154699},
        '{ 1258162,  1467137, 1258162, -4560421, 1314997}
    };

    // Coefficient rescaled to cf fraction bits; rows past the table pass through
    function automatic logic signed [63:0] coef_scaled(input int row, input int tap,
                                                        input int cf);
        logic signed [63:0] c;
        if (row < TABLE_ROWS)
            c = 64'(COEF_TABLE[row][tap]);
        else if (tap == int'(TAP_B0))
            c = 64'sd1 <<< TABLE_FRAC;
        else
            c = 64'sd0;
        if (cf >= TABLE_FRAC)
            return c <<< (cf - TABLE_FRAC);
        return ((c >>> (TABLE_FRAC - cf - 1)) + 64'sd1) >>> 1;
    endfunction

    // Controller to datapath commands
    typedef struct packed {
        logic start;    // load sample, shift input history
        logic rd_en;    // fetch a section's history row
        logic capture;  // latch fetched y1, y2
        logic mul_en;   // issue one product
        tap_t tap;      // which product
        logic fin;      // round, saturate, write back a section
        logic emit;     // load the output register
    } dp_cmd_t;

endpackage

// ----- sv/cascaded_biquad_iir_filter.sv -----
`timescale 1ns / 1ps

// Cascade of direct-form-I biquad sections on Q2.14 samples (Q2.22 fixed
// coefficients, Q4.28 section state). One multiply-accumulate unit is shared
// by every product: each section takes five products, a drain step and a
// write-back step, and a new sample is accepted only once the last one has
// run through every section, whatever sections_in_use says, since every
// section runs. The result sits in an output register, so the next sample is
// taken while it waits; a result that is still waiting when the next one is
// done holds the cascade until it leaves. Section history lives in a small RAM
// with one valid bit per section; reset and tuser (restart) clear those bits
// at once, so there is no clearing pass. Write cfg_wr_data only while idle.
module cascaded_biquad_iir_filter #(
    parameter  int NUM_SECTIONS = cbq_pkg::NUM_SECTIONS_DEF,
    parameter  int SAMPLE_WIDTH = cbq_pkg::SAMPLE_WIDTH_DEF,
    parameter  int COEF_WIDTH   = cbq_pkg::COEF_WIDTH_DEF,
    localparam int TDATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [TDATA_W-1:0]            s_axis_tdata,   // sample_in, zero pad
    input  logic                          s_axis_tuser,   // restart
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [TDATA_W-1:0]            m_axis_tdata,   // sample_out, zero pad
    output logic                          m_axis_tuser,   // saturated
    input  logic                          cfg_wr_en,
    input  logic [cbq_pkg::CFG_W-1:0]     cfg_wr_data     // sections_in_use
);

    import cbq_pkg::*;

    localparam int SEC_W = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;

    dp_cmd_t                        cmd;
    logic [SEC_W-1:0]               sec_idx;
    logic [SEC_W-1:0]               rd_idx;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;

    assign sample_in    = signed'(s_axis_tdata[SAMPLE_WIDTH-1:0]);
    assign m_axis_tdata = TDATA_W'(unsigned'(sample_out));

    cbq_ctrl #(
        .NUM_SECTIONS (NUM_SECTIONS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd),
        .sec_idx       (sec_idx),
        .rd_idx        (rd_idx)
    );

    cbq_datapath #(
        .NUM_SECTIONS (NUM_SECTIONS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sec_idx     (sec_idx),
        .rd_idx      (rd_idx),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sample_in   (sample_in),
        .restart     (s_axis_tuser),
        .sample_out  (sample_out),
        .saturated   (m_axis_tuser)
    );

endmodule

// ----- sv/cbq_ram.sv -----
`timescale 1ns / 1ps

module cbq_ram #(
    parameter  int WIDTH = 64,
    parameter  int DEPTH = 12,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/cbq_ctrl.sv -----
`timescale 1ns / 1ps

module cbq_ctrl #(
    parameter  int NUM_SECTIONS = cbq_pkg::NUM_SECTIONS_DEF,
    localparam int SEC_W        = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output cbq_pkg::dp_cmd_t    cmd,
    output logic [SEC_W-1:0]    sec_idx,
    output logic [SEC_W-1:0]    rd_idx
);

    import cbq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_FIN,
        ST_EMIT
    } state_t;

    localparam logic [SEC_W-1:0] LAST_SEC = SEC_W'(NUM_SECTIONS - 1);

    state_t            state_reg, state_next;
    tap_t              tap_reg, tap_next;
    logic [SEC_W-1:0]  sec_reg, sec_next;
    logic              ready_reg, ready_next;
    logic              ovalid_reg, ovalid_next;
    logic              last_sec;
    logic              out_free;

    assign last_sec = (sec_reg == LAST_SEC);
    assign out_free = !ovalid_reg || m_axis_tready;

    always_comb
    begin
        cmd         = '0;
        cmd.tap     = tap_reg;
        state_next  = state_reg;
        tap_next    = tap_reg;
        sec_next    = sec_reg;
        ready_next  = ready_reg;
        rd_idx      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid && ready_reg)
                begin
                    cmd.start  = 1'b1;
                    cmd.rd_en  = 1'b1;
                    ready_next = 1'b0;
                    tap_next   = TAP_B0;
                    sec_next   = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                cmd.mul_en  = 1'b1;
                cmd.capture = (tap_reg == TAP_B0);
                case (tap_reg)
                    TAP_B0:  tap_next = TAP_B1;
                    TAP_B1:  tap_next = TAP_B2;
                    TAP_B2:  tap_next = TAP_A1;
                    TAP_A1:  tap_next = TAP_A2;
                    TAP_A2:  state_next = ST_DRAIN;
                    default: tap_next = TAP_B0;
                endcase
            end
            ST_DRAIN:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.fin = 1'b1;
                if (last_sec)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    // fetch the next section's history while this one writes back
                    cmd.rd_en  = 1'b1;
                    rd_idx     = SEC_W'(sec_reg + 1'b1);
                    sec_next   = SEC_W'(sec_reg + 1'b1);
                    tap_next   = TAP_B0;
                    state_next = ST_MAC;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    ready_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase

        if (cmd.emit)
            ovalid_next = 1'b1;
        else if (m_axis_tready)
            ovalid_next = 1'b0;
        else
            ovalid_next = ovalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            tap_reg    <= TAP_B0;
            sec_reg    <= '0;
            ready_reg  <= 1'b1;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            tap_reg    <= tap_next;
            sec_reg    <= sec_next;
            ready_reg  <= ready_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign s_axis_tready = ready_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign sec_idx       = sec_reg;

endmodule

// ----- sv/cbq_datapath.sv -----
`timescale 1ns / 1ps

module cbq_datapath #(
    parameter  int NUM_SECTIONS = cbq_pkg::NUM_SECTIONS_DEF,
    parameter  int SAMPLE_WIDTH = cbq_pkg::SAMPLE_WIDTH_DEF,
    parameter  int COEF_WIDTH   = cbq_pkg::COEF_WIDTH_DEF,
    localparam int SEC_W        = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cbq_pkg::dp_cmd_t               cmd,
    input  logic [SEC_W-1:0]               sec_idx,
    input  logic [SEC_W-1:0]               rd_idx,
    input  logic                           cfg_wr_en,
    input  logic [cbq_pkg::CFG_W-1:0]      cfg_wr_data,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  logic                           restart,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out,
    output logic                           saturated
);

    import cbq_pkg::*;

    localparam int SF       = SAMPLE_WIDTH - 2;
    localparam int CF       = COEF_WIDTH - 2;
    localparam int MW       = COEF_WIDTH + STATE_W;
    localparam int OW       = STATE_W + 2;
    localparam int IN_SHL   = (SF <= STATE_FRAC) ? STATE_FRAC - SF : 0;
    localparam int IN_SHR   = (SF > STATE_FRAC) ? SF - STATE_FRAC : 0;
    localparam int IN_SHR1  = (IN_SHR > 0) ? IN_SHR - 1 : 0;
    localparam int OUT_SHR  = IN_SHL;
    localparam int OUT_SHR1 = (OUT_SHR > 0) ? OUT_SHR - 1 : 0;
    localparam int OUT_SHL  = IN_SHR;

    localparam logic signed [ACC_W-1:0] ST_MAX =
        ACC_W'((64'sd1 <<< (STATE_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] ST_MIN = ACC_W'(-(64'sd1 <<< (STATE_W - 1)));
    localparam logic signed [OW-1:0] O_MAX =
        OW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [OW-1:0] O_MIN = OW'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

    // Sample format to Q4.28 state
    function automatic logic signed [STATE_W-1:0] to_state(
        input logic signed [SAMPLE_WIDTH-1:0] v);
        logic signed [SAMPLE_WIDTH:0] t;
        t = (SAMPLE_WIDTH + 1)'(v);
        if (IN_SHR == 0)
            return STATE_W'(t) <<< IN_SHL;
        t = (t >>> IN_SHR1) + (SAMPLE_WIDTH + 1)'(1);
        return STATE_W'(t >>> 1);
    endfunction

    logic signed [COEF_WIDTH-1:0] coef_rom [NUM_SECTIONS][TAPS];

    for (genvar j = 0; j < NUM_SECTIONS; j++)
    begin : g_row
        for (genvar k = 0; k < TAPS; k++)
        begin : g_tap
            assign coef_rom[j][k] = COEF_WIDTH'(coef_scaled(j, k, CF));
        end
    end

    logic [CFG_W-1:0]               cfg_reg;
    logic signed [SAMPLE_WIDTH-1:0] hist0_reg, hist1_reg, hist0_next, hist1_next;
    logic [NUM_SECTIONS-1:0]        vld_reg, vld_next;
    logic                           mulv_reg;
    tap_t                           tapd_reg;
    logic signed [ACC_W-1:0]        prod_reg, prod_next;
    logic signed [ACC_W-1:0]        acc_reg, acc_next;
    logic signed [STATE_W-1:0]      u0_reg, u1_reg, u2_reg, u0_next, u1_next, u2_next;
    logic signed [STATE_W-1:0]      y1_reg, y2_reg, y1_next, y2_next;
    logic signed [STATE_W-1:0]      tapout_reg, tapout_next;
    logic                           sat_reg, sat_next;
    logic signed [SAMPLE_WIDTH-1:0] sout_reg, sout_next;
    logic                           osat_reg, osat_next;

    logic [CFG_W-1:0]               cfg_m1;
    logic [SEC_W-1:0]               act_m1;
    logic signed [COEF_WIDTH-1:0]   coef_sel;
    logic signed [STATE_W-1:0]      opnd_sel;
    logic signed [MW-1:0]           mul_full;
    logic signed [ACC_W-1:0]        rnd_a, rnd_q;
    logic signed [STATE_W-1:0]      y_st;
    logic                           y_clip;
    logic signed [OW-1:0]           o_ext, o_val, o_cl;
    logic                           o_clip;
    logic [2*STATE_W-1:0]           ram_rdata;
    logic signed [SAMPLE_WIDTH-1:0] hist_a, hist_b;

    // Last section in use, with zero taken as one and overrange clamped
    assign cfg_m1 = cfg_reg - 1'b1;
    always_comb
    begin
        if (cfg_reg == '0)
            act_m1 = '0;
        else if (int'(cfg_reg) > NUM_SECTIONS)
            act_m1 = SEC_W'(NUM_SECTIONS - 1);
        else
            act_m1 = SEC_W'(cfg_m1);
    end

    cbq_ram #(
        .WIDTH (2 * STATE_W),
        .DEPTH (NUM_SECTIONS)
    ) u_hist_ram (
        .clk     (clk),
        .wr_en   (cmd.fin),
        .wr_addr (sec_idx),
        .wr_data ({y1_reg, y_st}),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_idx),
        .rd_data (ram_rdata)
    );

    // Shared multiplier
    always_comb
    begin
        case (cmd.tap)
            TAP_B0:
            begin
                coef_sel = coef_rom[sec_idx][0];
                opnd_sel = u0_reg;
            end
            TAP_B1:
            begin
                coef_sel = coef_rom[sec_idx][1];
                opnd_sel = u1_reg;
            end
            TAP_B2:
            begin
                coef_sel = coef_rom[sec_idx][2];
                opnd_sel = u2_reg;
            end
            TAP_A1:
            begin
                coef_sel = coef_rom[sec_idx][3];
                opnd_sel = y1_reg;
            end
            TAP_A2:
            begin
                coef_sel = coef_rom[sec_idx][4];
                opnd_sel = y2_reg;
            end
            default:
            begin
                coef_sel = '0;
                opnd_sel = '0;
            end
        endcase
    end

    assign mul_full  = MW'(coef_sel) * MW'(opnd_sel);
    assign prod_next = ACC_W'(mul_full);

    // Accumulate: b terms add, a terms subtract, b0 restarts the sum
    always_comb
    begin
        acc_next = acc_reg;
        if (mulv_reg)
        begin
            case (tapd_reg)
                TAP_B0:          acc_next = prod_reg;
                TAP_B1, TAP_B2:  acc_next = acc_reg + prod_reg;
                TAP_A1, TAP_A2:  acc_next = acc_reg - prod_reg;
                default:         acc_next = acc_reg;
            endcase
        end
    end

    // Round half up to Q4.28 and saturate
    assign rnd_a = (acc_reg >>> (CF - 1)) + ACC_W'(1);
    assign rnd_q = rnd_a >>> 1;

    always_comb
    begin
        y_clip = 1'b0;
        if (rnd_q > ST_MAX)
        begin
            y_st   = STATE_W'(ST_MAX);
            y_clip = 1'b1;
        end
        else if (rnd_q < ST_MIN)
        begin
            y_st   = STATE_W'(ST_MIN);
            y_clip = 1'b1;
        end
        else
        begin
            y_st = STATE_W'(rnd_q);
        end
    end

    // Tapped section back to sample format
    assign o_ext = OW'(tapout_reg);
    always_comb
    begin
        if (OUT_SHL > 0)
            o_val = o_ext <<< OUT_SHL;
        else if (OUT_SHR > 0)
            o_val = ((o_ext >>> OUT_SHR1) + OW'(1)) >>> 1;
        else
            o_val = o_ext;

        o_clip = 1'b0;
        if (o_val > O_MAX)
        begin
            o_cl   = O_MAX;
            o_clip = 1'b1;
        end
        else if (o_val < O_MIN)
        begin
            o_cl   = O_MIN;
            o_clip = 1'b1;
        end
        else
        begin
            o_cl = o_val;
        end
    end

    assign hist_a = restart ? '0 : hist0_reg;
    assign hist_b = restart ? '0 : hist1_reg;

    always_comb
    begin
        hist0_next  = hist0_reg;
        hist1_next  = hist1_reg;
        vld_next    = vld_reg;
        u0_next     = u0_reg;
        u1_next     = u1_reg;
        u2_next     = u2_reg;
        y1_next     = y1_reg;
        y2_next     = y2_reg;
        tapout_next = tapout_reg;
        sat_next    = sat_reg;
        sout_next   = sout_reg;
        osat_next   = osat_reg;

        if (cmd.start)
        begin
            u0_next    = to_state(sample_in);
            u1_next    = to_state(hist_a);
            u2_next    = to_state(hist_b);
            hist1_next = hist_a;
            hist0_next = sample_in;
            sat_next   = 1'b0;
            if (restart)
                vld_next = '0;
        end

        if (cmd.capture)
        begin
            // a row never written since restart reads as zero history
            y1_next = vld_reg[sec_idx] ? STATE_W'(ram_rdata[STATE_W-1:0]) : '0;
            y2_next = vld_reg[sec_idx] ? STATE_W'(ram_rdata[2*STATE_W-1:STATE_W]) : '0;
        end

        if (cmd.fin)
        begin
            vld_next[sec_idx] = 1'b1;
            u0_next = y_st;
            u1_next = y1_reg;
            u2_next = y2_reg;
            if (sec_idx == act_m1)
                tapout_next = y_st;
            if (y_clip && (sec_idx <= act_m1))
                sat_next = 1'b1;
        end

        if (cmd.emit)
        begin
            sout_next = SAMPLE_WIDTH'(o_cl);
            osat_next = sat_reg || o_clip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg   <= SECTIONS_RESET;
            hist0_reg <= '0;
            hist1_reg <= '0;
            vld_reg   <= '0;
            mulv_reg  <= 1'b0;
            tapd_reg  <= TAP_B0;
        end
        else
        begin
            if (cfg_wr_en)
                cfg_reg <= cfg_wr_data;
            hist0_reg <= hist0_next;
            hist1_reg <= hist1_next;
            vld_reg   <= vld_next;
            mulv_reg  <= cmd.mul_en;
            tapd_reg  <= cmd.tap;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        u0_reg     <= u0_next;
        u1_reg     <= u1_next;
        u2_reg     <= u2_next;
        y1_reg     <= y1_next;
        y2_reg     <= y2_next;
        tapout_reg <= tapout_next;
        sat_reg    <= sat_next;
        sout_reg   <= sout_next;
        osat_reg   <= osat_next;
    end

    assign sample_out = sout_reg;
    assign saturated  = osat_reg;

endmodule

// ----- sim/tb_cascaded_biquad_iir_filter.sv -----
`timescale 1ns / 1ps

module tb_cascaded_biquad_iir_filter;
    import cbq_pkg::*;

    localparam int N_SEC      = NUM_SECTIONS_DEF;
    localparam int SMP_W      = SAMPLE_WIDTH_DEF;
    localparam int COEF_FRAC  = COEF_WIDTH_DEF - 2;
    localparam int OUT_SHIFT  = STATE_FRAC - (SMP_W - 2);
    localparam int RAND_ITEMS = 700;
    localparam int IDLE_LIMIT = 3000;
    localparam int EXP_DEPTH  = 1024;

    localparam logic signed [63:0] STATE_MAX = 64'sd2147483647;
    localparam logic signed [63:0] STATE_MIN = -64'sd2147483648;
    localparam logic signed [63:0] SMP_MAX   = 64'sd32767;
    localparam logic signed [63:0] SMP_MIN   = -64'sd32768;

    typedef struct {
        logic signed [SMP_W-1:0] sample;
        logic                    sat;
    } filtered_t;

    logic              clk;
    logic              rst_n         = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [SMP_W-1:0]  s_axis_tdata  = '0;   // sample_in
    logic              s_axis_tuser  = 1'b0;  // restart
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [SMP_W-1:0]  m_axis_tdata;          // sample_out
    logic              m_axis_tuser;          // saturated
    logic              cfg_wr_en     = 1'b0;
    logic [CFG_W-1:0]  cfg_wr_data   = '0;    // sections_in_use

    // Filter state as the block should hold it
    logic [CFG_W-1:0]        sections_reg = SECTIONS_RESET;
    logic signed [SMP_W-1:0] in_hist [2];
    logic signed [31:0]      sec_hist [2*N_SEC];

    // Expected results, written by the sender and read by the checker
    filtered_t exp_mem [EXP_DEPTH];
    int        exp_wr       = 0;
    int        exp_rd       = 0;
    filtered_t rx_want;
    int        fail_count   = 0;
    int        burst_left   = 0;
    bit        tx_held      = 1'b0;
    int        stall_left   = 0;
    int        idle_cycles  = 0;
    int        rx_cycle     = 0;

    cascaded_biquad_iir_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic cascade_predict(input logic signed [SMP_W-1:0] smp, input logic rs,
                                   output filtered_t res);
        logic signed [63:0] u0, u1, u2, y1, y2, acc, y, tap, o;
        logic signed [63:0] c [TAPS];
        int                 active;
        int                 j;
        int                 k;
        logic               sat;
        sat = 1'b0;
        tap = '0;
        if (rs)
        begin
            in_hist[0] = '0;
            in_hist[1] = '0;
            for (j = 0; j < 2*N_SEC; j++)
                sec_hist[j] = '0;
        end
        if (sections_reg == 0)
            active = 1;
        else if (sections_reg > N_SEC)
            active = N_SEC;
        else
            active = sections_reg;
        u0 = smp;
        u0 = u0 <<< (STATE_FRAC - (SMP_W - 2));
        u1 = in_hist[0];
        u1 = u1 <<< (STATE_FRAC - (SMP_W - 2));
        u2 = in_hist[1];
        u2 = u2 <<< (STATE_FRAC - (SMP_W - 2));
        in_hist[1] = in_hist[0];
        in_hist[0] = smp;
        for (j = 0; j < N_SEC; j++)
        begin
            y1 = sec_hist[2*j];
            y2 = sec_hist[2*j+1];
            for (k = 0; k < TAPS; k++)
                c[k] = COEF_TABLE[j][k];
            // 64-bit sum wraps, as the accumulator does
            acc = c[TAP_B0]*u0 + c[TAP_B1]*u1 + c[TAP_B2]*u2 - c[TAP_A1]*y1 - c[TAP_A2]*y2;
            y = ((acc >>> (COEF_FRAC - 1)) + 64'sd1) >>> 1;
            if (y > STATE_MAX)
            begin
                y = STATE_MAX;
                if (j < active)
                    sat = 1'b1;
            end
            else if (y < STATE_MIN)
            begin
                y = STATE_MIN;
                if (j < active)
                    sat = 1'b1;
            end
            sec_hist[2*j+1] = y1[31:0];
            sec_hist[2*j]   = y[31:0];
            if (j == active - 1)
                tap = y;
            u0 = y;
            u1 = y1;
            u2 = y2;
        end
        o = ((tap >>> (OUT_SHIFT - 1)) + 64'sd1) >>> 1;
        if (o > SMP_MAX)
        begin
            o = SMP_MAX;
            sat = 1'b1;
        end
        else if (o < SMP_MIN)
        begin
            o = SMP_MIN;
            sat = 1'b1;
        end
        res.sample = o[SMP_W-1:0];
        res.sat    = sat;
    endtask

    task automatic drop_valid();
        if (tx_held)
        begin
            s_axis_tvalid <= 1'b0;
            tx_held = 1'b0;
        end
    endtask

    task automatic send_sample(input logic signed [SMP_W-1:0] smp, input logic rs);
        filtered_t want;
        int        gap;
        if (burst_left == 0)
        begin
            drop_valid();
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 10);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= rs;
        tx_held = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        cascade_predict(smp, rs, want);
        exp_mem[exp_wr % EXP_DEPTH] = want;
        exp_wr++;
        burst_left--;
    endtask

    task automatic wait_drained();
        drop_valid();
        while (exp_rd != exp_wr)
            @(posedge clk);
    endtask

    task automatic set_sections(input logic [CFG_W-1:0] count);
        wait_drained();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sections_reg = count;
    endtask

    // Reset value of the section count, zero history at start-up
    task automatic test_startup_impulse();
        send_sample(16'sd16384, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sd0, 1'b0);
    endtask

    // Full-scale square wave near the passband
    task automatic test_full_scale();
        int i;
        for (i = 0; i < 12; i++)
            send_sample((i % 12 < 6) ? 16'sh7fff : 16'sh8000, 1'b0);
    endtask

    task automatic test_restart();
        send_sample(16'sd20000, 1'b1);
        send_sample(16'sh8000, 1'b1);
        send_sample(-16'sd1, 1'b0);
    endtask

    // Counts out of range clamp to one and to the full cascade
    task automatic test_section_counts();
        set_sections(4'd0);
        send_sample(16'sd12000, 1'b1);
        send_sample(16'sd1, 1'b0);
        set_sections(4'd15);
        send_sample(16'sh7fff, 1'b0);
        set_sections(4'd13);
        send_sample(16'sh8000, 1'b0);
        set_sections(4'd1);
        send_sample(16'sd32767, 1'b0);
        set_sections(4'd12);
        send_sample(16'sd0, 1'b0);
    endtask

    task automatic test_random_stream();
        int                      sent;
        int                      kind;
        int                      len;
        int                      period;
        int                      ph;
        int                      i;
        logic signed [SMP_W-1:0] amp;
        logic signed [SMP_W-1:0] smp;
        logic                    rs;
        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            if ($urandom_range(0, 11) == 0)
                set_sections(CFG_W'($urandom_range(0, 15)));
            kind   = $urandom_range(0, 9);
            len    = $urandom_range(8, 40);
            period = $urandom_range(6, 48);
            ph     = $urandom_range(0, 47);
            amp    = SMP_W'($urandom_range(1000, 32767));
            for (i = 0; i < len; i++)
            begin
                if (kind < 6)
                    smp = (((i + ph) % period) < period / 2) ? amp : ~amp;
                else if (kind < 8)
                    smp = SMP_W'($urandom_range(0, 65535));
                else if (kind == 8)
                    smp = SMP_W'(int'($urandom_range(0, 63)) - 32);
                else
                    case ($urandom_range(0, 3))
                        0: smp = 16'sh7fff;
                        1: smp = 16'sh8000;
                        2: smp = 16'sd0;
                        default: smp = -16'sd1;
                    endcase
                rs = (i == 0) && ($urandom_range(0, 7) == 0);
                send_sample(smp, rs);
                sent++;
            end
        end
    endtask

    initial
    begin
        for (int n = 0; n < 2*N_SEC; n++)
            sec_hist[n] = '0;
        in_hist[0] = '0;
        in_hist[1] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_startup_impulse();
        test_full_scale();
        test_restart();
        test_section_counts();
        test_random_stream();
        wait_drained();
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Receiver: free-running and stalling stretches in turn
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (stall_left != 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (rx_cycle[10] && $urandom_range(0, 5) == 0)
                stall_left <= $urandom_range(1, 40);
            else if (!rx_cycle[10] && rx_cycle[9] && $urandom_range(0, 1) == 0)
                stall_left <= $urandom_range(1, 3);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (exp_rd == exp_wr)
            begin
                $error("result beat with nothing expected: sample_out %0d saturated %0b",
                       $signed(m_axis_tdata), m_axis_tuser);
                fail_count++;
            end
            else
            begin
                rx_want = exp_mem[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (m_axis_tdata !== rx_want.sample)
                begin
                    $error("sample_out: expected %0d, actual %0d",
                           rx_want.sample, $signed(m_axis_tdata));
                    fail_count++;
                end
                if (m_axis_tuser !== rx_want.sat)
                begin
                    $error("saturated: expected %0b, actual %0b", rx_want.sat, m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    // Stop if no beat moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
